// ----- hdl/tah_pkg.sv -----
// Shared types and constants for the thermal alarm block.
// Used by every module of the block and by its checker; depends on nothing.
package tah_pkg;

  // Mode codes as they appear on the result channel.
  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_MONITOR = 3'd1,
    MODE_ALARM   = 3'd2,
    MODE_TIMEOUT = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_HYSTERESIS = 2'd1,
    REG_MAX_ALARM  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;
  localparam int TEMP_W      = 15;
  localparam int HYS_W       = 11;
  localparam int MAXT_W      = 17;
  localparam int TIME_W      = 32;

  // Register limits and reset values.
  localparam logic signed [TEMP_W-1:0] THR_LO    = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] THR_HI    = 15'sd8500;
  localparam logic signed [TEMP_W-1:0] THR_RESET = 15'sd2500;
  localparam logic [HYS_W-1:0]         HYS_LO    = 11'd10;
  localparam logic [HYS_W-1:0]         HYS_HI    = 11'd2000;
  localparam logic [HYS_W-1:0]         HYS_RESET = 11'd100;
  localparam logic [MAXT_W-1:0]        MAXT_LO    = 17'd1000;
  localparam logic [MAXT_W-1:0]        MAXT_HI    = 17'd120000;
  localparam logic [MAXT_W-1:0]        MAXT_RESET = 17'd10000;

  // Current register settings.
  typedef struct packed {
    logic signed [TEMP_W-1:0] thr;
    logic [HYS_W-1:0]         hys;
    logic [MAXT_W-1:0]        maxt;
  } cfg_t;

  // One update request.
  typedef struct packed {
    logic                     init_good;
    logic signed [TEMP_W-1:0] sensor_temperature;
    logic                     read_good;
    logic [TIME_W-1:0]        time_now;
  } in_item_t;

  // One update result.
  typedef struct packed {
    logic                     init_taken;
    logic                     read_taken;
    logic signed [TEMP_W-1:0] held_temperature;
    logic                     buzzer;
    mode_t                    mode;
  } out_item_t;

endpackage

// ----- hdl/tah_cfg_regs.sv -----
// Configuration registers of the thermal alarm block, clamped on write.
// Depends on tah_pkg.
module tah_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tah_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tah_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tah_pkg::cfg_t                      cfg
);
  import tah_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic signed [TEMP_W-1:0] thr_wr;
  logic [HYS_W-1:0]         hys_wr;
  logic [MAXT_W-1:0]        maxt_wr;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Clamp the written value and steer it to the addressed register.
  always_comb begin
    thr_wr  = $signed(cfg_data[TEMP_W-1:0]);
    hys_wr  = cfg_data[HYS_W-1:0];
    maxt_wr = cfg_data[MAXT_W-1:0];
    if (thr_wr < THR_LO) thr_wr = THR_LO;
    if (thr_wr > THR_HI) thr_wr = THR_HI;
    if (hys_wr < HYS_LO) hys_wr = HYS_LO;
    if (hys_wr > HYS_HI) hys_wr = HYS_HI;
    if (maxt_wr < MAXT_LO) maxt_wr = MAXT_LO;
    if (maxt_wr > MAXT_HI) maxt_wr = MAXT_HI;

    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD:  cfg_nxt.thr  = thr_wr;
        REG_HYSTERESIS: cfg_nxt.hys  = hys_wr;
        REG_MAX_ALARM:  cfg_nxt.maxt = maxt_wr;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr  <= THR_RESET;
      cfg_r.hys  <= HYS_RESET;
      cfg_r.maxt <= MAXT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/tah_in_stage.sv -----
// Input register of the thermal alarm block: holds one accepted update.
// Depends on tah_pkg.
module tah_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tah_pkg::in_item_t   in_item,
  input  logic                advance,
  output logic                item_valid,
  output tah_pkg::in_item_t   item
);
  import tah_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // The register frees up in the same cycle the core consumes it.
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hdl/tah_core.sv -----
// Alarm state machine with its timers and the result register.
// Depends on tah_pkg; fed by tah_in_stage and tah_cfg_regs.
module tah_core #(
  parameter int SAMPLE_PERIOD_MS = 500,
  parameter int RETRY_PERIOD_MS  = 1000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  tah_pkg::in_item_t   item,
  output logic                advance,
  input  tah_pkg::cfg_t       cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output tah_pkg::out_item_t  out_item
);
  import tah_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic signed [TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic [TIME_W-1:0] last_sample_r, last_sample_nxt;
  logic [TIME_W-1:0] alarm_start_r, alarm_start_nxt;
  logic [TIME_W-1:0] last_retry_r, last_retry_nxt;
  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  logic signed [TEMP_W-1:0] thr;
  logic signed [TEMP_W:0]   off_level;
  logic signed [TEMP_W-1:0] temp;
  logic [TIME_W-1:0]        now;
  logic                     alarm_expired;
  logic                     sample_due;
  logic                     retry_due;
  logic                     fresh;
  logic                     init_taken;
  mode_t                    mode_v;

  // An update is processed when the result register is free or being drained.
  assign advance = item_valid && (!out_valid_r || out_ready);

  assign now       = item.time_now;
  assign temp      = item.sensor_temperature;
  assign thr       = cfg.thr;
  assign off_level = {thr[TEMP_W-1], thr} - $signed({5'b0, cfg.hys});

  // Elapsed times are modulo-2^32 differences.
  assign alarm_expired = (now - alarm_start_r) >= TIME_W'(cfg.maxt);
  assign retry_due     = (now - last_retry_r) >= TIME_W'(RETRY_PERIOD_MS);

  // Next state and result for the update in the input register.
  always_comb begin
    mode_v          = mode_r;
    last_temp_nxt   = last_temp_r;
    last_sample_nxt = last_sample_r;
    alarm_start_nxt = alarm_start_r;
    last_retry_nxt  = last_retry_r;
    init_taken      = 1'b0;
    fresh           = 1'b0;

    if (mode_v == MODE_ALARM && alarm_expired) mode_v = MODE_TIMEOUT;

    sample_due = (mode_v != MODE_INIT) &&
                 ((now - last_sample_r) >= TIME_W'(SAMPLE_PERIOD_MS));
    if (sample_due) begin
      last_sample_nxt = now;
      if (item.read_good) begin
        last_temp_nxt = temp;
        fresh         = 1'b1;
      end else begin
        mode_v = MODE_ERROR;
      end
    end

    mode_nxt = mode_v;
    case (mode_v)
      MODE_INIT: begin
        init_taken = 1'b1;
        mode_nxt   = item.init_good ? MODE_MONITOR : MODE_ERROR;
      end
      MODE_MONITOR: begin
        if (fresh && temp >= thr) begin
          mode_nxt        = MODE_ALARM;
          alarm_start_nxt = now;
        end
      end
      MODE_ALARM, MODE_TIMEOUT: begin
        if (fresh && $signed({temp[TEMP_W-1], temp}) <= off_level) mode_nxt = MODE_MONITOR;
      end
      MODE_ERROR: begin
        if (retry_due) begin
          last_retry_nxt = now;
          init_taken     = 1'b1;
          if (item.init_good) mode_nxt = MODE_MONITOR;
        end
      end
      default: mode_nxt = MODE_ERROR;
    endcase

    out_nxt.mode             = mode_nxt;
    out_nxt.buzzer           = (mode_nxt == MODE_ALARM);
    out_nxt.held_temperature = last_temp_nxt;
    out_nxt.read_taken       = sample_due;
    out_nxt.init_taken       = init_taken;
  end

  // State registers move only when an update is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_INIT;
      last_temp_r   <= '0;
      last_sample_r <= '0;
      alarm_start_r <= '0;
      last_retry_r  <= '0;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      last_temp_r   <= last_temp_nxt;
      last_sample_r <= last_sample_nxt;
      alarm_start_r <= alarm_start_nxt;
      last_retry_r  <= last_retry_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- hdl/thermal_alarm_hysteresis_fsm.sv -----
// Over-temperature alarm with hysteresis, alarm timeout and sensor recovery.
// Top level; instantiates tah_cfg_regs, tah_in_stage and tah_core (tah_pkg).
//
// Usage:
//   in_*  : one update per transfer (time in ms, read result, init result).
//   out_* : exactly one result per update, in order (mode, buzzer, held
//           temperature, and which input fields the update consumed).
//   cfg_* : register writes (0 threshold, 1 hysteresis, 2 max alarm time),
//           clamped to their legal ranges; other indexes are ignored.
//           Write only while no update is in flight.
// An input transfer passes the input register, then the state logic into the result
// register, before out_tvalid rises.
// Throughput is one update per cycle while out_tready stays high; the alarm state
// and timers update in the cycle an update moves into the result register.
// When the receiver stalls, the result register holds and one more update
// waits in the input register; in_tready then drops until out_tready returns.
// Reset (rst_n low, synchronous) empties both registers, returns the state
// machine to init with all timers and the held temperature at zero, and
// restores the register defaults 2500, 100 and 10000.
module thermal_alarm_hysteresis_fsm #(
  parameter int SAMPLE_PERIOD_MS = 500,
  parameter int RETRY_PERIOD_MS  = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0: time_now[31:0], read_good[32],
  // sensor_temperature[47:33], init_good[48], unused [55:49].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tah_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Fields from bit 0: mode[2:0], buzzer[3], held_temperature[18:4],
  // read_taken[19], init_taken[20], zero fill [23:21].
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tah_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tah_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tah_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tah_pkg::*;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_ITEM_W = $bits(out_item_t);

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  item;
  out_item_t out_item;
  logic      item_valid;
  logic      advance;

  // Field packing of the stream words.
  assign in_item   = in_item_t'(in_tdata[IN_ITEM_W-1:0]);
  assign out_tdata = {(OUT_TDATA_W - OUT_ITEM_W)'(0), out_item};

  tah_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tah_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tah_core #(
    .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS),
    .RETRY_PERIOD_MS  (RETRY_PERIOD_MS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .cfg        (cfg),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item)
  );

endmodule

// ----- hdl/tah_checker.sv -----
// Port-level checks of the thermal alarm block, bound to its top level.
// Depends on tah_pkg and thermal_alarm_hysteresis_fsm.
module tah_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tah_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tah_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The buzzer sounds exactly in the alarm mode.
  a_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] == (out_tdata[2:0] == MODE_ALARM)))
    else $error("buzzer disagrees with mode");

  // An init attempt ends in monitoring or in the error mode.
  a_init_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |->
      (out_tdata[2:0] == MODE_MONITOR) || (out_tdata[2:0] == MODE_ERROR))
    else $error("init attempt left an unexpected mode");

  // With the result register empty, a new update is always taken.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Reset leaves no result pending at the first edge after its release.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind thermal_alarm_hysteresis_fsm tah_checker u_tah_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
